### rtl/fls_pkg.sv
// shared types and codes for the free-list slot allocator
`timescale 1ns / 1ps

package fls_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_NULL_FREE = 2'd2;

   // request kind carried in the action field
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // source of the slot field in a result beat
   localparam logic [1:0] SLOT_SEL_ZERO   = 2'd0;
   localparam logic [1:0] SLOT_SEL_HEAD   = 2'd1;
   localparam logic [1:0] SLOT_SEL_CARVED = 2'd2;

   // fixed field widths
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;

   // controller to datapath commands
   typedef struct packed {
      logic                push;
      logic                pop_start;
      logic                pop_finish;
      logic                carve;
      logic                load_rsp;
      logic [1:0]          slot_sel;
      logic [STATUS_W-1:0] status;
   } fls_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic list_avail;
      logic carve_avail;
      logic free_in_pool;
      logic rsp_busy;
   } fls_stat_type;

endpackage

### rtl/fls_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fls_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fls_datapath.sv
// allocator datapath: list head, bump counter, link ram and result register
`timescale 1ns / 1ps

module fls_datapath import fls_pkg::*; #(
   parameter int POOL_SLOTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  fls_cmd_type         cmd,
   input  logic [SLOT_W-1:0]   free_slot,
   input  logic                rsp_ready,
   output fls_stat_type        stat,
   output logic                rsp_valid,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int LINK_DEPTH = (POOL_SLOTS < 1024) ? POOL_SLOTS : 1024;
   localparam int AW         = $clog2(LINK_DEPTH);
   localparam int CW         = $clog2(POOL_SLOTS + 1);
   localparam int LW         = SLOT_W + 1;

   logic [SLOT_W-1:0]   head_ff, head_in;
   logic                nonempty_ff, nonempty_in;
   logic [CW-1:0]       carved_ff, carved_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LW-1:0]       link_rd;
   logic [CW+SLOT_W-1:0] carved_ext;

   // link ram: {next-valid flag, next slot}
   fls_ram #(
      .WIDTH (LW),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (free_slot[AW-1:0]),
      .wr_data ({nonempty_ff, head_ff}),
      .rd_en   (cmd.pop_start),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (link_rd)
   );

   // status toward the controller
   assign stat.list_avail   = nonempty_ff && ({7'd0, head_ff} < 17'(POOL_SLOTS));
   assign stat.carve_avail  = carved_ff < CW'(POOL_SLOTS);
   assign stat.free_in_pool = {7'd0, free_slot} < 17'(POOL_SLOTS);
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;

   // list head and bump counter next state
   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      carved_in   = carved_ff;
      if (cmd.push) begin
         head_in     = free_slot;
         nonempty_in = 1'b1;
      end else if (cmd.pop_finish) begin
         head_in     = link_rd[SLOT_W-1:0];
         nonempty_in = link_rd[SLOT_W];
      end
      if (cmd.carve) begin
         carved_in = carved_ff + CW'(1);
      end
   end

   // result slot selection
   assign carved_ext = {{SLOT_W{1'b0}}, carved_ff};

   always_comb begin
      unique case (cmd.slot_sel)
         SLOT_SEL_HEAD:   rsp_slot_in = head_ff;
         SLOT_SEL_CARVED: rsp_slot_in = carved_ext[SLOT_W-1:0];
         default:         rsp_slot_in = '0;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         carved_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         carved_ff    <= carved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_status_ff <= cmd.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### rtl/fls_ctrl.sv
// allocator controller: decodes request beats and sequences list pops
`timescale 1ns / 1ps

module fls_ctrl import fls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         action,
   input  logic         free_is_null,
   input  fls_stat_type stat,
   output logic         req_ready,
   output fls_cmd_type  cmd
);

   localparam logic S_IDLE     = 1'b0;
   localparam logic S_POP_WAIT = 1'b1;

   logic state_ff, state_in;
   logic accept;

   // no beat is taken while reset is held
   assign req_ready = !reset && (state_ff == S_IDLE) && !stat.rsp_busy;
   assign accept    = req_valid && req_ready;

   // command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_rsp = 1'b1;
               cmd.slot_sel = SLOT_SEL_ZERO;
               cmd.status   = STATUS_OK;
               if (action == ACTION_ALLOC) begin
                  priority if (stat.list_avail) begin
                     cmd.pop_start = 1'b1;
                     cmd.slot_sel  = SLOT_SEL_HEAD;
                     state_in      = S_POP_WAIT;
                  end else if (stat.carve_avail) begin
                     cmd.carve    = 1'b1;
                     cmd.slot_sel = SLOT_SEL_CARVED;
                  end else begin
                     cmd.status = STATUS_EXHAUSTED;
                  end
               end else begin
                  if (free_is_null) begin
                     cmd.status = STATUS_NULL_FREE;
                  end else begin
                     cmd.push = stat.free_in_pool;
                  end
               end
            end
         end
         S_POP_WAIT: begin
            // link read data is back, move the head
            cmd.pop_finish = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/free_list_slot_allocator.sv
// top level of the free-list slot allocator
`timescale 1ns / 1ps

// Hands out fixed-size slots from a pool of POOL_SLOTS. Each request beat is
// an allocate or a free; each produces exactly one response beat carrying the
// slot index (zero for frees and failures) and a status. Allocates pop the
// head of a LIFO free list whose next links live in a synchronous link RAM;
// with the list empty they take the next never-used slot from a bump counter.
// An allocate served from the list holds off the next request until the
// registered read of the link RAM has yielded the new head. A new request is
// taken while the previous response is still waiting, as long as the
// response register is freed in the same cycle. No clearing pass follows
// reset: the block is ready as soon as reset drops.

module free_list_slot_allocator import fls_pkg::*; #(
   parameter int POOL_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] free_slot, [15:10] zero
   input  logic [1:0]  req_tuser,   // [0] action, [1] free_is_null
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] slot, [15:10] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   fls_cmd_type         cmd;
   fls_stat_type        stat;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [STATUS_W-1:0] rsp_status;

   fls_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .action       (req_tuser[0]),
      .free_is_null (req_tuser[1]),
      .stat         (stat),
      .req_ready    (req_tready),
      .cmd          (cmd)
   );

   fls_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .free_slot  (req_tdata[SLOT_W-1:0]),
      .rsp_ready  (rsp_tready),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {6'd0, rsp_slot};
   assign rsp_tuser = rsp_status;

   // a pop from the list blocks requests in the following cycle, in which the pop finishes
   a_pop_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_start |=> !req_tready && cmd.pop_finish)
      else $error("pop did not wait for link read");

   // every accepted request beat yields a response beat
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // failed requests report slot zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> rsp_tdata == 16'd0)
      else $error("nonzero slot on failed request");

endmodule
